// ===== rtl/tdac_pkg.sv =====
//------------------------------------------------------------------------------
// tdac_pkg
// Shared types and codes of the table driven automaton checker.
//------------------------------------------------------------------------------
package tdac_pkg;

  typedef enum logic [1:0] {
    KIND_ADD_STATE = 2'd0,
    KIND_ADD_TRANS = 2'd1,
    KIND_SYMBOL    = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NAME_RD,
    ST_NAME_CMP,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_TGT_RD,
    ST_TGT_CMP,
    ST_WRITE,
    ST_SYM_RD,
    ST_SYM_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/tdac_in_if.sv =====
//------------------------------------------------------------------------------
// tdac_in_if
// Input channel: valid, ready and one input item.
//------------------------------------------------------------------------------
interface tdac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] node_name;
  logic [7:0] symbol;
  logic [7:0] target_name;
  logic       last;

  modport source (output valid, kind, node_name, symbol, target_name, last,
                  input ready);
  modport sink (input valid, kind, node_name, symbol, target_name, last,
                output ready);
endinterface

// ===== rtl/tdac_out_if.sv =====
//------------------------------------------------------------------------------
// tdac_out_if
// Output channel: valid, ready and one result item.
//------------------------------------------------------------------------------
interface tdac_out_if;
  logic valid;
  logic ready;
  logic chain_valid;

  modport source (output valid, chain_valid, input ready);
  modport sink (input valid, chain_valid, output ready);
endinterface

// ===== rtl/table_driven_automaton_checker.sv =====
//------------------------------------------------------------------------------
// table_driven_automaton_checker
// Loads an automaton into on-chip tables and checks chains of symbols.
//------------------------------------------------------------------------------
// One item at a time; a transfer is taken in the idle cycle that follows each item.
// Add-state is handled in the idle state. A chain symbol walks up to K stored transitions
// of the current state, with a read step and a compare step per slot. Add-transition
// scans up to N stored states for the source name, then for the target name, a read
// and a compare per state, plus count read, count check and write.
// A result waits in the output register; only the last symbol of the next chain
// stalls behind it. Reset clears the state count, the walk and the chain flags.
module table_driven_automaton_checker #(
  parameter int STATE_SLOTS      = 64,
  parameter int TRANSITION_SLOTS = 32
) (
  input logic clk,
  input logic rst,
  tdac_in_if.sink    in_ch,
  tdac_out_if.source out_ch
);
  import tdac_pkg::*;

  localparam int SW = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
  localparam int TW = (TRANSITION_SLOTS > 1) ? $clog2(TRANSITION_SLOTS) : 1;
  localparam int CW = $clog2(STATE_SLOTS + 1);
  localparam int KW = $clog2(TRANSITION_SLOTS + 1);
  localparam int AW = SW + TW;
  localparam int TD = 1 << AW;

  // Memories.
  logic [7:0]    name_mem [STATE_SLOTS];
  logic [KW-1:0] cnt_mem  [STATE_SLOTS];
  logic [7:0]    sym_mem  [TD];
  logic [CW-1:0] tgt_mem  [TD];

  logic [7:0]    name_rd;
  logic [KW-1:0] cnt_rd;
  logic [7:0]    sym_rd;
  logic [CW-1:0] tgt_rd;

  logic [SW-1:0] name_addr;
  logic [SW-1:0] cnt_addr;
  logic [AW-1:0] tr_addr;

  state_t state, state_next;

  // Control and item registers.
  logic [CW-1:0] state_count;
  logic [CW-1:0] current_index;
  logic          chain_failed;
  logic          chain_started;
  logic [7:0]    item_name, item_sym, item_tgt;
  logic          item_last;
  logic [CW-1:0] scan;
  logic [KW-1:0] k;
  logic [CW-1:0] src;
  logic [KW-1:0] n;
  logic          out_valid;
  logic          out_data;

  logic          scan_end;
  logic [CW-1:0] cur;
  logic          done_go;

  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.chain_valid = out_data;

  wire in_xfer = in_ch.valid && in_ch.ready;

  // The walk restarts at state 0 when no chain is open.
  assign cur      = chain_started ? current_index : '0;
  assign scan_end = (scan >= state_count);

  // A chain verdict may leave only once the previous one has been taken.
  assign done_go  = !(item_last && out_valid && !out_ch.ready);

  always_comb begin
    name_addr = scan[SW-1:0];
    cnt_addr  = (state == ST_CNT_RD) ? src[SW-1:0] : cur[SW-1:0];
    tr_addr   = (state == ST_WRITE) ? {src[SW-1:0], n[TW-1:0]}
                                    : {cur[SW-1:0], k[TW-1:0]};
  end

  always_ff @(posedge clk) begin
    name_rd <= name_mem[name_addr];
    cnt_rd  <= cnt_mem[cnt_addr];
    sym_rd  <= sym_mem[tr_addr];
    tgt_rd  <= tgt_mem[tr_addr];
    if (state == ST_IDLE && in_xfer && in_ch.kind == KIND_ADD_STATE
        && state_count < CW'(STATE_SLOTS)) begin
      name_mem[state_count[SW-1:0]] <= in_ch.node_name;
      cnt_mem[state_count[SW-1:0]]  <= '0;
    end
    if (state == ST_WRITE) begin
      sym_mem[tr_addr] <= item_sym;
      tgt_mem[tr_addr] <= scan_end ? CW'(STATE_SLOTS) : scan;
      cnt_mem[src[SW-1:0]] <= n + KW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (kind_t'(in_ch.kind))
            KIND_ADD_TRANS: state_next = ST_NAME_RD;
            KIND_SYMBOL:    state_next = ST_SYM_RD;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_NAME_RD:  state_next = scan_end ? ST_IDLE : ST_NAME_CMP;
      ST_NAME_CMP: state_next = (name_rd == item_name) ? ST_CNT_RD : ST_NAME_RD;
      ST_CNT_RD:   state_next = ST_CNT_CHK;
      ST_CNT_CHK:  state_next = (cnt_rd >= KW'(TRANSITION_SLOTS)) ? ST_IDLE : ST_TGT_RD;
      ST_TGT_RD:   state_next = scan_end ? ST_WRITE : ST_TGT_CMP;
      ST_TGT_CMP:  state_next = (name_rd == item_tgt) ? ST_WRITE : ST_TGT_RD;
      ST_WRITE:    state_next = ST_IDLE;
      ST_SYM_RD:   state_next = ST_SYM_CMP;
      ST_SYM_CMP: begin
        // Each compare sees slot k, read in the cycle before; a miss reads the next slot.
        if (chain_failed && chain_started) state_next = ST_DONE;
        else if (cur >= state_count) state_next = ST_DONE;
        else if (k >= cnt_rd) state_next = ST_DONE;
        else if (sym_rd == item_sym) state_next = ST_DONE;
        else state_next = ST_SYM_RD;
      end
      ST_DONE:     state_next = done_go ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  logic sym_hit;
  assign sym_hit = !(chain_failed && chain_started) && (cur < state_count)
                   && (k < cnt_rd) && (sym_rd == item_sym);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      state_count   <= '0;
      current_index <= '0;
      chain_failed  <= 1'b0;
      chain_started <= 1'b0;
      out_valid     <= 1'b0;
      scan          <= '0;
      k             <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && done_go && item_last) begin
        out_valid <= 1'b1;
        out_data  <= !chain_failed;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          scan <= '0;
          k    <= '0;
          if (in_xfer) begin
            item_name <= in_ch.node_name;
            item_sym  <= in_ch.symbol;
            item_tgt  <= in_ch.target_name;
            item_last <= in_ch.last;
            if (in_ch.kind == KIND_ADD_STATE && state_count < CW'(STATE_SLOTS))
              state_count <= state_count + CW'(1);
          end
        end
        ST_NAME_CMP: begin
          if (name_rd == item_name) begin
            src  <= scan;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        ST_CNT_CHK: begin
          n    <= cnt_rd;
          scan <= '0;
        end
        ST_TGT_CMP: if (name_rd != item_tgt) scan <= scan + CW'(1);
        ST_SYM_CMP: begin
          if (state_next == ST_SYM_RD) k <= k + KW'(1);
          if (state_next == ST_DONE) begin
            if (sym_hit) current_index <= tgt_rd;
            else if (!(chain_failed && chain_started)) current_index <= cur;
            if (!chain_started) chain_failed <= !sym_hit;
            else if (!sym_hit) chain_failed <= 1'b1;
          end
        end
        ST_DONE: begin
          if (done_go) chain_started <= !item_last;
        end
        default: ;
      endcase
    end
  end

  // Slot k is addressed during the read step, so the compare step that follows
  // always works on the registered read of that same slot.

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready)
    else $error("input accepted while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state_count <= CW'(STATE_SLOTS))
    else $error("state count overflow");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result outside chain end");
endmodule

// ===== tb/tb_table_driven_automaton_checker.sv =====
//------------------------------------------------------------------------------
// tb_table_driven_automaton_checker
// Builds automata and walks symbol chains through the checker. A behavioral
// copy of the tables predicts each chain verdict, which is compared in order.
//------------------------------------------------------------------------------
module tb_table_driven_automaton_checker;
  import tdac_pkg::*;

  localparam int NSTATES   = 64;
  localparam int NTRANS    = 32;
  localparam int DEAD      = NSTATES;
  localparam int N_RANDOM  = 2000;
  localparam int LIMIT     = 3000000;
  localparam int DRAIN     = 400;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] node_name;
    logic [7:0] symbol;
    logic [7:0] target_name;
    logic       last;
  } item_t;

  // Directed row: an item plus an optional typed-in verdict.
  typedef struct packed {
    item_t item;
    logic  has_exp;
    logic  exp_valid;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdac_in_if  in_ch ();
  tdac_out_if out_ch ();

  table_driven_automaton_checker #(
    .STATE_SLOTS     (NSTATES),
    .TRANSITION_SLOTS(NTRANS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor tables.
  logic [7:0] names [NSTATES];
  int         n_states;
  int         trans_cnt [NSTATES];
  logic [7:0] trans_sym [NSTATES][NTRANS];
  int         trans_tgt [NSTATES][NTRANS];
  int         cur;
  bit         failed;
  bit         started;

  bit verdict_q [$];
  int errors;
  int cycles;
  bit quiet;        // no idling in the final stretch
  bit hold_long;    // long receiver hold-off request

  function automatic int find_name(logic [7:0] nm);
    for (int i = 0; i < n_states; i++)
      if (names[i] == nm) return i;
    return DEAD;
  endfunction

  // Applies one item to the predictor; returns 1 when it yields a verdict.
  function automatic bit predict_chain(item_t it, output bit verdict);
    int s;
    bit hit;
    verdict = 1'b0;
    case (it.kind)
      KIND_ADD_STATE: begin
        if (n_states < NSTATES) begin
          names[n_states] = it.node_name;
          trans_cnt[n_states] = 0;
          n_states++;
        end
        return 1'b0;
      end
      KIND_ADD_TRANS: begin
        s = find_name(it.node_name);
        if (s < NSTATES && trans_cnt[s] < NTRANS) begin
          trans_sym[s][trans_cnt[s]] = it.symbol;
          trans_tgt[s][trans_cnt[s]] = find_name(it.target_name);
          trans_cnt[s]++;
        end
        return 1'b0;
      end
      KIND_SYMBOL: begin
        if (!started) begin
          cur = 0;
          failed = 1'b0;
        end
        if (!failed) begin
          hit = 1'b0;
          if (cur < n_states) begin
            for (int k = 0; k < trans_cnt[cur]; k++)
              if (trans_sym[cur][k] == it.symbol) begin
                cur = trans_tgt[cur][k];
                hit = 1'b1;
                break;
              end
          end
          if (!hit) failed = 1'b1;
        end
        if (it.last) begin
          verdict = !failed;
          started = 1'b0;
          return 1'b1;
        end
        started = 1'b1;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t mk(kind_t k, int nm, int sy, int tg, bit lst);
    item_t it;
    it.kind = k;
    it.node_name = nm[7:0];
    it.symbol = sy[7:0];
    it.target_name = tg[7:0];
    it.last = lst;
    return it;
  endfunction

  // Drives one item and waits for its transfer, then updates the predictor.
  task automatic send_item(item_t it, bit has_exp, bit exp_valid, bit may_idle);
    bit v;
    int gap;
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.node_name   <= it.node_name;
    in_ch.symbol      <= it.symbol;
    in_ch.target_name <= it.target_name;
    in_ch.last        <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_chain(it, v)) begin
      if (has_exp && v != exp_valid) begin
        $error("directed chain_valid: expected %0b, predictor %0b", exp_valid, v);
        errors++;
      end
      verdict_q.push_back(v);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("chain_valid: unexpected result %0b", out_ch.chain_valid);
        errors++;
      end else begin
        bit e;
        e = verdict_q.pop_front();
        if (out_ch.chain_valid !== e) begin
          $error("chain_valid: expected %0b, actual %0b", e, out_ch.chain_valid);
          errors++;
        end
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        n = 0;
        while (n < 3000) begin
          @(posedge clk);
          n++;
        end
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Random chain symbol biased toward stored transitions.
  function automatic item_t rand_symbol(bit lst);
    int s;
    int sy;
    sy = $urandom_range(0, 255);
    s = (started && !failed) ? cur : 0;
    if (s < n_states && trans_cnt[s] > 0 && $urandom_range(0, 9) < 8)
      sy = trans_sym[s][$urandom_range(0, trans_cnt[s] - 1)];
    return mk(KIND_SYMBOL, $urandom_range(0, 255), sy, $urandom_range(0, 255), lst);
  endfunction

  initial begin
    row_t rows [$];
    item_t it;
    int r;
    int nm;
    errors = 0;
    quiet = 1'b0;
    hold_long = 1'b0;
    n_states = 0;
    cur = 0;
    failed = 1'b0;
    started = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ADD_STATE;
    in_ch.node_name = '0;
    in_ch.symbol = '0;
    in_ch.target_name = '0;
    in_ch.last = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No states: chain fails; unused kind and stray last are ignored.
    rows.push_back({mk(KIND_SYMBOL, 0, 0, 0, 1), 1'b1, 1'b0});
    rows.push_back({mk(KIND_UNUSED, 255, 255, 255, 1), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 0, 1, 0, 1), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_STATE, 0, 0, 0, 1), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_STATE, 255, 0, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_STATE, 255, 0, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 0, 0, 255, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 255, 255, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 0, 7, 99, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 77, 7, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 0, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 255, 0, 1), 1'b1, 1'b1});
    // Dead target then a further symbol fails; failed chain waits for last.
    rows.push_back({mk(KIND_SYMBOL, 0, 7, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 7, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 0, 0, 1), 1'b1, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 3, 0, 1), 1'b1, 1'b0});
    // Table edit mid-chain.
    rows.push_back({mk(KIND_SYMBOL, 0, 0, 0, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_ADD_TRANS, 255, 42, 255, 0), 1'b0, 1'b0});
    rows.push_back({mk(KIND_SYMBOL, 0, 42, 0, 1), 1'b0, 1'b0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp_valid, 1'b1);
    // Fill transitions of state 0 past the slot limit.
    for (int k = 0; k < NTRANS + 2; k++)
      send_item(mk(KIND_ADD_TRANS, 0, 100 + k, 0, 0), 1'b0, 1'b0, 1'b0);
    send_item(mk(KIND_SYMBOL, 0, 100 + NTRANS - 1, 0, 1), 1'b0, 1'b0, 1'b0);
    send_item(mk(KIND_SYMBOL, 0, 100 + NTRANS, 0, 1), 1'b0, 1'b0, 1'b0);
    wait_drained();

    // Random: grow the automaton with states and edges, mostly chains over its edges.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) hold_long = 1'b1;
      if (n == N_RANDOM / 2) wait_drained();
      if (n > N_RANDOM * 9 / 10) quiet = 1'b1;
      r = $urandom_range(0, 99);
      nm = $urandom_range(0, 15);
      if (n_states < NSTATES && (r < 8 || n_states < 3))
        it = mk(KIND_ADD_STATE, (r < 2) ? $urandom_range(0, 255) : nm,
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
      else if (r < 25)
        it = mk(KIND_ADD_TRANS, (r < 12) ? $urandom_range(0, 255) : nm,
                $urandom_range(0, 7) | ($urandom_range(0, 9) == 0 ? 8'hF8 : 8'h00),
                (r < 14) ? $urandom_range(0, 255) : $urandom_range(0, 15),
                $urandom_range(0, 1));
      else if (r < 27)
        it = mk(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 1));
      else
        it = rand_symbol($urandom_range(0, 4) == 0);
      send_item(it, 1'b0, 1'b0, 1'b1);
    end

    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
